/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// The macros expect a signal named clk, and FC_ASSERT also rst_n, in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge except while reset is asserted.
`define FC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define FC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/fircirc_pkg.sv */
package fircirc_pkg;

  // Field widths of the request and result items.
  localparam int TAP_W  = 6;
  localparam int VAL_W  = 16;
  localparam int OUT_W  = 16;
  localparam int PROD_W = 32;

  // Packed width of the input tdata, rounded up to whole bytes.
  localparam int IN_DATA_W = ((TAP_W + VAL_W + 7) / 8) * 8;

  // Rounding and saturation constants for the Q1.15 result.
  localparam int FRAC_BITS  = 15;
  localparam int ROUND_BIAS = 16384;
  localparam int OUT_MAX    = 32767;
  localparam int OUT_MIN    = -32768;

  // Request kinds carried on in_tuser.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } fc_state_t;

endpackage

/* hw/rtl/fir_filter_circular_unit.sv */
// Channel   Dir  Ports                         Contents
// in_       in   tvalid tready tdata tuser     tap_index, value; cmd on tuser
// out_      out  tvalid tready tdata tuser     filtered; saturated on tuser
//
// A coefficient request is taken and gives no result.
// A sample request runs one multiply-accumulate per tap, issued one per cycle
// from the two memories, then waits for the pipeline to drain.
// Reset clears the pointers and the per-entry valid bits, so both memories
// read as zero until written; no clearing pass is needed.
// The result waits in the output register while out_tready is low; a new
// request is still taken, and the next result holds until the register frees.
module fir_filter_circular_unit #(
  parameter int TAPS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [5:0] tap_index, [21:6] value, [23:22] unused
  input  logic [fircirc_pkg::IN_DATA_W-1:0] in_tdata,
  // [0] cmd
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] filtered
  output logic [fircirc_pkg::OUT_W-1:0]   out_tdata,
  // [0] saturated
  output logic                            out_tuser
);
  import fircirc_pkg::*;

  localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int ACC_W = PROD_W + AW;
  localparam int QW    = ACC_W - FRAC_BITS;

  localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);
  localparam logic signed [QW-1:0] Q_MAX = QW'(OUT_MAX);
  localparam logic signed [QW-1:0] Q_MIN = QW'(OUT_MIN);

  // Request decode
  logic                    in_acc;
  logic                    smp_acc;
  logic                    cof_acc;
  logic [TAP_W-1:0]        in_tap;
  logic signed [VAL_W-1:0] in_val;
  logic                    cof_in_range;

  assign in_acc       = in_tvalid && in_tready;
  assign smp_acc      = in_acc && (in_tuser == CMD_SAMPLE);
  assign cof_acc      = in_acc && (in_tuser == CMD_COEF);
  assign in_tap       = in_tdata[TAP_W-1:0];
  assign in_val       = in_tdata[TAP_W+VAL_W-1:TAP_W];
  assign cof_in_range = 32'(in_tap) < 32'(TAPS);

  // Sequencer registers
  fc_state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic          s1_v_r, s2_v_r;
  logic          issue;
  logic          out_load;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (smp_acc) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (cnt_r == LAST_ADDR) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!s1_v_r && !s2_v_r) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_RUN:   issue     = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  out_load  = !out_tvalid || out_tready;
      default:  ;
    endcase
  end

  // Tap counter, delay-line read pointer and newest-slot pointer
  always_comb begin
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    slot_nxt = slot_r;
    if (smp_acc) begin
      cnt_nxt  = '0;
      pos_nxt  = slot_r;
      slot_nxt = (slot_r == '0) ? LAST_ADDR : slot_r - 1'b1;
    end else if (issue) begin
      cnt_nxt = cnt_r + 1'b1;
      pos_nxt = (pos_r == LAST_ADDR) ? '0 : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pos_r   <= '0;
      slot_r  <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      slot_r  <= slot_nxt;
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
    end
  end

  // Coefficient and delay-line memories with per-entry valid bits.
  // The sample is written on the accept edge and first read on the edge after it,
  // so the newest tap always sees the fresh sample.
  logic [VAL_W-1:0] coef_mem [TAPS];
  logic [VAL_W-1:0] dly_mem  [TAPS];
  logic [TAPS-1:0]  coef_vld_r;
  logic [TAPS-1:0]  dly_vld_r;
  logic [VAL_W-1:0] coef_rd_r;
  logic [VAL_W-1:0] dly_rd_r;
  logic             coef_rv_r;
  logic             dly_rv_r;

  always_ff @(posedge clk) begin
    if (cof_acc && cof_in_range) coef_mem[AW'(in_tap)] <= in_val;
    if (smp_acc) dly_mem[slot_r] <= in_val;
    coef_rd_r <= coef_mem[cnt_r];
    dly_rd_r  <= dly_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
      dly_vld_r  <= '0;
      coef_rv_r  <= 1'b0;
      dly_rv_r   <= 1'b0;
    end else begin
      if (cof_acc && cof_in_range) coef_vld_r[AW'(in_tap)] <= 1'b1;
      if (smp_acc) dly_vld_r[slot_r] <= 1'b1;
      coef_rv_r <= coef_vld_r[cnt_r];
      dly_rv_r  <= dly_vld_r[pos_r];
    end
  end

  // Multiply stage: an entry never written reads as zero.
  logic signed [VAL_W-1:0]  coef_eff;
  logic signed [VAL_W-1:0]  dly_eff;
  logic signed [PROD_W-1:0] prod_r;

  assign coef_eff = coef_rv_r ? coef_rd_r : '0;
  assign dly_eff  = dly_rv_r  ? dly_rd_r  : '0;

  always_ff @(posedge clk) begin
    prod_r <= coef_eff * dly_eff;
  end

  // Accumulate stage, cleared when a sample is taken.
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (smp_acc) begin
      acc_nxt = '0;
    end else if (s2_v_r) begin
      acc_nxt = acc_r + {{AW{prod_r[PROD_W-1]}}, prod_r};
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Round to nearest, then saturate to 16 bits.
  logic signed [ACC_W-1:0] rnd;
  logic signed [QW-1:0]    q;
  logic [OUT_W-1:0]        q_sat;
  logic                    q_ovf;

  assign rnd = acc_r + ACC_W'(ROUND_BIAS);
  assign q   = rnd[ACC_W-1:FRAC_BITS];

  always_comb begin
    q_ovf = 1'b1;
    if (q > Q_MAX) begin
      q_sat = Q_MAX[OUT_W-1:0];
    end else if (q < Q_MIN) begin
      q_sat = Q_MIN[OUT_W-1:0];
    end else begin
      q_sat = q[OUT_W-1:0];
      q_ovf = 1'b0;
    end
  end

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r;
  logic             out_sat_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= q_sat;
      out_sat_r  <= q_ovf;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule

/* hw/rtl/fircirc_chk.sv */
`include "assert_macros.svh"

module fircirc_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [fircirc_pkg::OUT_W-1:0] out_tdata,
  input logic                          out_tuser
);
  import fircirc_pkg::*;

  // Handshake and result terms shared by the properties below.
  logic           out_stall;
  logic           coef_acc;
  logic           smp_acc;
  logic           out_rail;
  logic [OUT_W:0] out_word;

  assign out_stall = out_tvalid && !out_tready;
  assign coef_acc  = in_tvalid && in_tready && (in_tuser == CMD_COEF);
  assign smp_acc   = in_tvalid && in_tready && (in_tuser == CMD_SAMPLE);
  assign out_rail  = (out_tdata == 16'h7FFF) || (out_tdata == 16'h8000);
  assign out_word  = {out_tuser, out_tdata};

  // A stalled result keeps its contents.
  `FC_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_word), "stalled result changed")

  // A saturated result sits at one end of the 16-bit range.
  `FC_ASSERT(a_sat_rail, out_tvalid && out_tuser |-> out_rail, "saturated result off the rails")

  // No result is offered on the edge after reset.
  `FC_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_tvalid, "result offered after reset")

  // A coefficient write never creates a result.
  `FC_ASSERT(a_coef_silent, coef_acc && !out_tvalid |=> !out_tvalid, "coefficient gave a result")

  // Straight after a sample is taken no further request is taken.
  `FC_ASSERT(a_busy, smp_acc |=> !in_tready, "request taken during filtering")

endmodule

bind fir_filter_circular_unit fircirc_chk u_fircirc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
